@@ hw/rtl/tdf_pkg.sv @@
// shared constants for the trial division factoriser
`default_nettype none
package tdf_pkg;
    localparam int unsigned MAX_RESULTS = 32;
    localparam int unsigned RUN_W = $clog2(MAX_RESULTS);
endpackage
`default_nettype wire

@@ hw/rtl/tdf_front.sv @@
// input stage: flags values below two, holds number and flag in a two entry queue
`default_nettype none
module tdf_front #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [WIDTH-1:0] s_number,
    output logic                  q_valid,
    input  wire logic             q_ready,
    output logic [WIDTH-1:0]      q_number,
    output logic                  q_small
);
    logic [WIDTH:0] mem_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;
    logic           push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign push = s_valid && s_ready;
    assign pop = q_valid && q_ready;
    assign q_number = mem_reg[rp_reg][WIDTH-1:0];
    assign q_small = mem_reg[rp_reg][WIDTH];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= {(s_number < WIDTH'(2)), s_number};
        end
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/tdf_divider.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none
module tdf_divider #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  done,
    output logic [WIDTH-1:0]      quotient,
    output logic [WIDTH-1:0]      remainder
);
    localparam int unsigned CW = $clog2(WIDTH + 1);
    logic [WIDTH-1:0] q_reg, d_reg;
    logic [WIDTH:0]   r_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, done_reg;
    logic [WIDTH:0]   sh, diff;

    assign sh = {r_reg[WIDTH-1:0], q_reg[WIDTH-1]};
    assign diff = sh - {1'b0, d_reg};
    assign done = done_reg;
    assign quotient = q_reg;
    assign remainder = r_reg[WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            d_reg <= divisor;
            r_reg <= '0;
            cnt_reg <= CW'(WIDTH);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CW'(1);
            if (!diff[WIDTH]) begin
                r_reg <= diff;
                q_reg <= {q_reg[WIDTH-2:0], 1'b1};
            end else begin
                r_reg <= sh;
                q_reg <= {q_reg[WIDTH-2:0], 1'b0};
            end
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start) busy_reg <= 1'b1;
            else if (busy_reg && cnt_reg == CW'(1)) busy_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/tdf_back.sv @@
// factoring sequencer: trial divisions on the shared divider, result register
`default_nettype none
module tdf_back #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire logic [WIDTH-1:0] q_number,
    input  wire logic             q_small,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [WIDTH-1:0]      m_prime_factor,
    output logic                  m_has_factor,
    output logic                  m_last
);
    import tdf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_WAIT  = 4'b0100,
        S_HOLD  = 4'b1000
    } state_t;

    state_t           state_reg;
    logic [WIDTH-1:0] rem_reg, d_reg;
    logic [RUN_W-1:0] k_reg;
    logic             ov_reg;
    logic [WIDTH-1:0] f_reg;
    logic             h_reg, l_reg;
    logic [WIDTH-1:0] pf_reg;
    logic             pl_reg;
    logic             dv_done;
    logic [WIDTH-1:0] quo, rmd;
    logic             out_free;

    tdf_divider #(.WIDTH(WIDTH)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(state_reg == S_START),
        .dividend(rem_reg), .divisor(d_reg), .done(dv_done),
        .quotient(quo), .remainder(rmd)
    );

    assign out_free = !ov_reg || m_ready;
    assign q_ready = (state_reg == S_IDLE) && out_free;
    assign m_valid = ov_reg;
    assign m_prime_factor = f_reg;
    assign m_has_factor = h_reg;
    assign m_last = l_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end else begin
            if (ov_reg && m_ready) ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid && out_free) begin
                        rem_reg <= q_number;
                        d_reg <= WIDTH'(2);
                        k_reg <= '0;
                        if (q_small) begin
                            ov_reg <= 1'b1;
                            f_reg <= '0;
                            h_reg <= 1'b0;
                            l_reg <= 1'b1;
                        end else begin
                            state_reg <= S_START;
                        end
                    end
                end
                S_START: state_reg <= S_WAIT;
                S_WAIT: begin
                    if (dv_done) begin
                        if (quo < d_reg) begin
                            pf_reg <= rem_reg;
                            pl_reg <= 1'b1;
                            state_reg <= S_HOLD;
                        end else if (rmd == '0) begin
                            if (k_reg == RUN_W'(MAX_RESULTS - 1)) begin
                                pf_reg <= rem_reg;
                                pl_reg <= 1'b1;
                                state_reg <= S_HOLD;
                            end else begin
                                pf_reg <= d_reg;
                                pl_reg <= 1'b0;
                                rem_reg <= quo;
                                k_reg <= k_reg + RUN_W'(1);
                                state_reg <= S_HOLD;
                            end
                        end else begin
                            d_reg <= d_reg + WIDTH'(1);
                            state_reg <= S_START;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        ov_reg <= 1'b1;
                        f_reg <= pf_reg;
                        l_reg <= pl_reg;
                        h_reg <= 1'b1;
                        state_reg <= pl_reg ? S_IDLE : S_START;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/trial_division_factorization.sv @@
// top level of the trial division factoriser
// channel | dir | ports                                      | role
// s_      | in  | s_valid s_ready s_number                   | numbers to factor
// m_      | out | m_valid m_ready m_prime_factor m_has_factor m_last | factor beats
// each trial division runs on the one shared restoring divider
// a division that yields a factor passes through a hold state that loads the result register
// a number n is tried against divisors from two up to about sqrt(n), a prime is worst
// synchronous active low reset empties the input queue and the output register
// a stalled m_ready holds the sequencer at its next beat; two numbers can wait meanwhile
`default_nettype none
module trial_division_factorization #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [WIDTH-1:0] s_number,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [WIDTH-1:0]      m_prime_factor,
    output logic                  m_has_factor,
    output logic                  m_last
);
    logic             q_valid, q_ready, q_small;
    logic [WIDTH-1:0] q_number;

    tdf_front #(.WIDTH(WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_number(s_number), .q_valid(q_valid), .q_ready(q_ready),
        .q_number(q_number), .q_small(q_small)
    );

    tdf_back #(.WIDTH(WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_number(q_number), .q_small(q_small), .m_valid(m_valid),
        .m_ready(m_ready), .m_prime_factor(m_prime_factor),
        .m_has_factor(m_has_factor), .m_last(m_last)
    );
endmodule
`default_nettype wire

@@ hw/rtl/tdf_checker.sv @@
// port level checks for the trial division factoriser
`default_nettype none
module tdf_checker #(
    parameter int unsigned WIDTH = 32
) (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic [WIDTH-1:0] m_prime_factor,
    input wire logic             m_has_factor,
    input wire logic             m_last
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prime_factor))
        else $error("result beat changed while stalled");
    a_nofac_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_factor |-> m_last && m_prime_factor == '0)
        else $error("no factor beat not last or nonzero");
    a_fac_ge2: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_has_factor |-> m_prime_factor > WIDTH'(1))
        else $error("factor below two");
endmodule
bind trial_division_factorization tdf_checker #(.WIDTH(WIDTH)) u_tdf_checker (.*);
`default_nettype wire

@@ bench/trial_division_factorization_tb.sv @@
// testbench for the trial division factoriser: queue-fed driver, checking monitor
`default_nettype none
module trial_division_factorization_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WIDTH = 32;
    localparam longint unsigned LIMIT = 20000000;
    localparam int unsigned HOLD_CYCLES = 3000;

    typedef struct packed {
        logic [WIDTH-1:0] prime_factor;
        logic             has_factor;
        logic             last;
    } factor_beat_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [WIDTH-1:0] s_number = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [WIDTH-1:0] m_prime_factor;
    logic             m_has_factor;
    logic             m_last;

    logic [WIDTH-1:0] numbers_to_send[$];
    factor_beat_t     expected_factors[$];
    longint unsigned  cycle_count = 0;
    int unsigned      numbers_accepted = 0;
    int unsigned      beats_seen = 0;
    int unsigned      mismatches = 0;
    int unsigned      hold_left = 0;
    bit               hold_done = 1'b0;

    trial_division_factorization #(.WIDTH(WIDTH)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_number(s_number),
        .m_valid(m_valid), .m_ready(m_ready), .m_prime_factor(m_prime_factor),
        .m_has_factor(m_has_factor), .m_last(m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic bit quiet_stretch();
        return numbers_accepted >= 45 && numbers_accepted < 65;
    endfunction

    task automatic factorise(input logic [WIDTH-1:0] number);
        longint unsigned rem;
        longint unsigned div;
        int unsigned     k;
        factor_beat_t    b;
        rem = 64'(number);
        div = 2;
        k = 0;
        if (rem < 2) begin
            b = '{prime_factor: '0, has_factor: 1'b0, last: 1'b1};
            expected_factors = {expected_factors, b};
            return;
        end
        while (div <= rem / div) begin
            if (rem % div == 0) begin
                if (k == tdf_pkg::MAX_RESULTS - 1) begin
                    b = '{prime_factor: rem[WIDTH-1:0], has_factor: 1'b1, last: 1'b1};
                    expected_factors = {expected_factors, b};
                    return;
                end
                b = '{prime_factor: div[WIDTH-1:0], has_factor: 1'b1, last: 1'b0};
                expected_factors = {expected_factors, b};
                k++;
                rem = rem / div;
            end else begin
                div++;
            end
        end
        b = '{prime_factor: rem[WIDTH-1:0], has_factor: 1'b1, last: 1'b1};
        expected_factors = {expected_factors, b};
    endtask

    // driver
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                factorise(s_number);
                numbers_accepted <= numbers_accepted + 1;
            end
            if (!s_valid || s_ready) begin
                if (numbers_to_send.size() > 0 &&
                    (quiet_stretch() || $urandom_range(99) >= 32)) begin
                    s_number <= numbers_to_send.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!hold_done && numbers_accepted >= 10) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                beats_seen <= beats_seen + 1;
                if (expected_factors.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected beat: factor %0d has %0b last %0b",
                                 m_prime_factor, m_has_factor, m_last);
                end else begin
                    factor_beat_t e;
                    e = expected_factors.pop_front();
                    if (e.prime_factor !== m_prime_factor || e.has_factor !== m_has_factor ||
                        e.last !== m_last) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     e.prime_factor, e.has_factor, e.last,
                                     m_prime_factor, m_has_factor, m_last);
                    end
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet_stretch() || $urandom_range(99) >= 32;
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [WIDTH-1:0] smooth_number();
        longint unsigned v;
        int unsigned     p;
        int unsigned     primes[10];
        primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};
        v = 1;
        repeat ($urandom_range(40, 1)) begin
            p = primes[$urandom_range(9)];
            if (v * p <= 64'hFFFF_FFFF) v = v * p;
        end
        return v[WIDTH-1:0];
    endfunction

    initial begin
        logic [WIDTH-1:0] directed[$];
        int unsigned      pick;
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd97,
                     32'h8000_0000, 32'hFFFF_FFFF, 32'd65521, 32'd65536,
                     32'd1000003, 32'hFFFE_0001, 32'd1024, 32'd999, 32'd30030,
                     32'hC000_0000, 32'd49, 32'd121};
        numbers_to_send = directed;
        for (int i = 0; i < 80; i++) begin
            pick = $urandom_range(99);
            if (pick < 60)
                numbers_to_send = {numbers_to_send, WIDTH'($urandom_range(4095))};
            else if (pick < 90)
                numbers_to_send = {numbers_to_send, smooth_number()};
            else
                numbers_to_send = {numbers_to_send, WIDTH'($urandom_range(32'h3FFFF))};
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        while (numbers_to_send.size() > 0 || s_valid || expected_factors.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("factored %0d numbers into %0d beats, incl. extremes and a long output stall",
                 numbers_accepted, beats_seen);
        if (mismatches == 0 && expected_factors.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
hw/rtl/tdf_pkg.sv
hw/rtl/tdf_front.sv
hw/rtl/tdf_divider.sv
hw/rtl/tdf_back.sv
hw/rtl/trial_division_factorization.sv
hw/rtl/tdf_checker.sv
bench/trial_division_factorization_tb.sv
